[design/psu_pkg.sv]
package psu_pkg;

	// Table size and field widths
	localparam int PARTICLES  = 32;
	localparam int PIDX_W     = $clog2(PARTICLES);
	localparam int IDX_W      = 5;
	localparam int POS_W      = 32;
	localparam int FIT_W      = 64;
	localparam int GAIN_W     = 18;
	localparam int RAND_W     = 17;
	localparam int K_W        = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 320;

	// Latency of the arithmetic: lane pipeline then merge pipeline
	localparam int LANE_LAT   = 8;
	localparam int MERGE_LAT  = 3;
	localparam int CALC_CYC   = LANE_LAT + MERGE_LAT;
	localparam int CNT_W      = $clog2(CALC_CYC);

	typedef logic signed [POS_W-1:0] coord_t;
	typedef logic [FIT_W-1:0] fit_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INERTIA  = 3'd0,
		REG_COG_GAIN = 3'd1,
		REG_SOC_GAIN = 3'd2,
		REG_COG_RAND = 3'd3,
		REG_SOC_RAND = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CALC,
		S_DONE
	} seq_state_t;

	// Velocity coefficients: inertia and the two combined attraction gains
	typedef struct packed {
		logic [GAIN_W-1:0] w;
		logic [K_W-1:0]    k1;
		logic [K_W-1:0]    k2;
	} coef_t;

	// Operands of one axis
	typedef struct packed {
		logic   load;
		coord_t p;
		coord_t v;
		coord_t b;
		coord_t g;
	} lane_in_t;

	// Results of one axis
	typedef struct packed {
		coord_t pos;
		coord_t vel;
		fit_t   fourth;
	} lane_out_t;

	// One particle table entry
	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t vx;
		coord_t vy;
		coord_t bx;
		coord_t by;
		fit_t   bf;
	} entry_t;

	// Swarm best
	typedef struct packed {
		fit_t   f;
		coord_t x;
		coord_t y;
	} swarm_t;

	// Merged results of one request
	typedef struct packed {
		fit_t   fit;
		fit_t   pbf;
		coord_t pbx;
		coord_t pby;
		swarm_t sw;
	} merge_out_t;

	// Clamp a signed value to the 32-bit coordinate range
	function automatic coord_t sat32(input logic signed [38:0] v);
		coord_t r;
		if (v[38:31] == {8{v[38]}}) begin
			r = v[31:0];
		end else if (v[38]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

[design/psu_lane.sv]
module psu_lane (
	input  logic                clk,
	input  psu_pkg::coef_t      coef,
	input  psu_pkg::lane_in_t   lin,
	output psu_pkg::lane_out_t  lout
);
	import psu_pkg::*;

	// Operands stay stable for the whole request, so stages carry only results
	logic signed [32:0] diff_b;
	logic signed [32:0] diff_g;
	logic signed [50:0] mw_s1;
	logic signed [52:0] mc_s1;
	logic signed [52:0] ms_s1;
	logic signed [54:0] acc_s2;
	coord_t             vel_s3;
	coord_t             pos_s4;
	logic signed [63:0] pos_w;
	logic        [63:0] sq_s5;
	logic        [63:0] p11_s6;
	logic        [63:0] p01_s6;
	logic        [63:0] p00_s6;
	logic        [65:0] mid_s7;
	fit_t               fourth_s8;

	assign diff_b = 33'(lin.b) - 33'(lin.p);
	assign diff_g = 33'(lin.g) - 33'(lin.p);
	assign pos_w  = 64'(pos_s4);

	// Velocity products, rounded sum, new velocity and position
	always_ff @(posedge clk) begin
		mw_s1  <= 51'($signed({1'b0, coef.w})) * 51'(lin.v);
		mc_s1  <= 53'($signed({1'b0, coef.k1})) * 53'(diff_b);
		ms_s1  <= 53'($signed({1'b0, coef.k2})) * 53'(diff_g);
		acc_s2 <= 55'(mw_s1) + 55'(mc_s1) + 55'(ms_s1) + 55'sd32768;
		vel_s3 <= lin.load ? lin.v : sat32(39'(acc_s2 >>> 16));
		pos_s4 <= lin.load ? lin.p : sat32(39'(lin.p) + 39'(vel_s3));
	end

	// Fourth power: square, then the upper half of square times square
	always_ff @(posedge clk) begin
		sq_s5     <= pos_w * pos_w;
		p11_s6    <= 64'(sq_s5[63:32]) * 64'(sq_s5[63:32]);
		p01_s6    <= 64'(sq_s5[63:32]) * 64'(sq_s5[31:0]);
		p00_s6    <= 64'(sq_s5[31:0]) * 64'(sq_s5[31:0]);
		mid_s7    <= {1'b0, p01_s6, 1'b0} + 66'(p00_s6[63:32]);
		fourth_s8 <= p11_s6 + 64'(mid_s7[65:32]);
	end

	assign lout.pos    = pos_s4;
	assign lout.vel    = vel_s3;
	assign lout.fourth = fourth_s8;

endmodule

[design/psu_merge.sv]
module psu_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psu_pkg::lane_out_t   lx,
	input  psu_pkg::lane_out_t   ly,
	input  psu_pkg::entry_t      old,
	input  logic                 load,
	input  logic                 hit,
	input  logic                 commit,
	output psu_pkg::merge_out_t  mout,
	output psu_pkg::swarm_t      swarm_cur
);
	import psu_pkg::*;

	logic [64:0] fsum;
	fit_t        fit_s1;
	fit_t        pbf_s2;
	coord_t      pbx_s2;
	coord_t      pby_s2;
	swarm_t      sw_s3;
	swarm_t      swarm_q;
	logic        take;
	logic        stake;

	assign fsum  = 65'(lx.fourth) + 65'(ly.fourth);
	assign take  = load || (fit_s1 <= old.bf);
	assign stake = hit && !load && (pbf_s2 <= swarm_q.f);

	// Sum the axes, then personal best, then swarm best candidate
	always_ff @(posedge clk) begin
		fit_s1 <= fsum[64] ? '1 : fsum[63:0];
		pbf_s2 <= take ? fit_s1 : old.bf;
		pbx_s2 <= take ? lx.pos : old.bx;
		pby_s2 <= take ? ly.pos : old.by;
		sw_s3  <= stake ? swarm_t'{f: pbf_s2, x: pbx_s2, y: pby_s2} : swarm_q;
	end

	// Hold the swarm best; take the candidate once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swarm_q <= '{f: '1, x: '0, y: '0};
		end else if (commit) begin
			swarm_q <= sw_s3;
		end
	end

	assign mout.fit  = fit_s1;
	assign mout.pbf  = pbf_s2;
	assign mout.pbx  = pbx_s2;
	assign mout.pby  = pby_s2;
	assign mout.sw   = sw_s3;
	assign swarm_cur = swarm_q;

endmodule

[design/particle_swarm_update_unit.sv]
// Two-dimensional particle swarm update unit. It holds a table of PARTICLES entries
// (position, velocity, personal best) and one swarm best. A request with tuser low loads
// a particle's start state; with tuser high it runs one inertia-weighted velocity step,
// moves the particle, scores it as x^4 + y^4 and updates the personal and swarm bests.
// Each request gives exactly one result. Requests are handled one at a time: from one
// acceptance to the next, a request passes the accept state, a table read, the two axis
// lanes, the merge stage and a commit. The output register lets the next request in
// while a result waits; a result still waiting at commit time holds the unit.
// Configuration writes take effect for requests accepted from the next cycle on. Table
// entries are undefined until loaded.
module particle_swarm_update_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// particle_index[4:0], start_x[36:5], start_y[68:37], start_vel_x[100:69],
	// start_vel_y[132:101], zero fill[135:133]
	input  logic [psu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// operation[0]
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// new_x[31:0], new_y[63:32], fitness[127:64], particle_best_fitness[191:128],
	// swarm_best_fitness[255:192], swarm_best_x[287:256], swarm_best_y[319:288]
	output logic [psu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psu_pkg::GAIN_W-1:0]         cfg_data
);
	import psu_pkg::*;

	logic [GAIN_W-1:0]  w_q;
	logic [GAIN_W-1:0]  c1_q;
	logic [GAIN_W-1:0]  c2_q;
	logic [RAND_W-1:0]  r1_q;
	logic [RAND_W-1:0]  r2_q;
	logic [K_W-1:0]     k1_q;
	logic [K_W-1:0]     k2_q;
	coef_t              coef;

	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	coord_t             sx_q;
	coord_t             sy_q;
	coord_t             svx_q;
	coord_t             svy_q;
	logic               hit;
	logic               load;
	logic [PIDX_W-1:0]  addr;

	entry_t             entries_q [PARTICLES];
	entry_t             rd_q;
	entry_t             wr_entry;
	logic               mem_we;

	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_en;
	logic               commit;

	lane_in_t           lin_x;
	lane_in_t           lin_y;
	lane_out_t          lout_x;
	lane_out_t          lout_y;
	merge_out_t         mout;
	swarm_t             swarm_cur;

	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= GAIN_W'(47828);
			c1_q <= GAIN_W'(98054);
			c2_q <= GAIN_W'(98054);
			r1_q <= RAND_W'(32768);
			r2_q <= RAND_W'(32768);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INERTIA:  w_q  <= cfg_data;
				REG_COG_GAIN: c1_q <= cfg_data;
				REG_SOC_GAIN: c2_q <= cfg_data;
				REG_COG_RAND: r1_q <= cfg_data[RAND_W-1:0];
				REG_SOC_RAND: r2_q <= cfg_data[RAND_W-1:0];
				default: ;
			endcase
		end
	end

	// Combine gain and random factor, rounded to Q3.16
	always_ff @(posedge clk) begin
		k1_q <= K_W'((36'(c1_q) * 36'(r1_q) + 36'd32768) >> 16);
		k2_q <= K_W'((36'(c2_q) * 36'(r2_q) + 36'd32768) >> 16);
	end

	assign coef = '{w: w_q, k1: k1_q, k2: k2_q};

	// Capture the request
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= op_t'(s_axis_tuser);
			idx_q <= s_axis_tdata[4:0];
			sx_q  <= s_axis_tdata[36:5];
			sy_q  <= s_axis_tdata[68:37];
			svx_q <= s_axis_tdata[100:69];
			svy_q <= s_axis_tdata[132:101];
		end
	end

	assign hit  = 32'(idx_q) < 32'(PARTICLES);
	assign load = (op_q == OP_LOAD);
	assign addr = PIDX_W'(idx_q);

	// Particle table: one read port, one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= entries_q[addr];
		end
		if (mem_we) begin
			entries_q[addr] <= wr_entry;
		end
	end

	// Sequencer state and calculation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_CALC) ? cnt_q + 1'b1 : '0;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		commit        = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_CALC;
			end
			S_CALC: begin
				if (cnt_q == CNT_W'(CALC_CYC - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// One lane per axis
	assign lin_x = '{load: load, p: load ? sx_q : rd_q.px, v: load ? svx_q : rd_q.vx,
	                 b: rd_q.bx, g: swarm_cur.x};
	assign lin_y = '{load: load, p: load ? sy_q : rd_q.py, v: load ? svy_q : rd_q.vy,
	                 b: rd_q.by, g: swarm_cur.y};

	psu_lane u_lane_x (
		.clk  (clk),
		.coef (coef),
		.lin  (lin_x),
		.lout (lout_x)
	);

	psu_lane u_lane_y (
		.clk  (clk),
		.coef (coef),
		.lin  (lin_y),
		.lout (lout_y)
	);

	psu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lx        (lout_x),
		.ly        (lout_y),
		.old       (rd_q),
		.load      (load),
		.hit       (hit),
		.commit    (commit),
		.mout      (mout),
		.swarm_cur (swarm_cur)
	);

	// Write back the entry on commit
	assign mem_we   = commit && hit;
	assign wr_entry = '{px: lout_x.pos, py: lout_y.pos, vx: lout_x.vel, vy: lout_y.vel,
	                    bx: mout.pbx, by: mout.pby, bf: mout.pbf};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {mout.sw.y, mout.sw.x, mout.sw.f,
			               hit ? mout.pbf : '0,
			               hit ? mout.fit : '0,
			               hit ? lout_y.pos : '0,
			               hit ? lout_x.pos : '0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A result appears only out of the commit cycle
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside commit");

	// The swarm best fitness never gets worse
	a_swarm_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		swarm_cur.f <= $past(swarm_cur.f))
		else $error("swarm best fitness increased");

	// A table write is always followed by a presented result
	a_write_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> m_axis_tvalid)
		else $error("table written without result");

endmodule
